// ----- rtl/nitb_pkg.sv -----
// ============================================================================
// nitb_pkg: shared types and constants for the interval timer bank
// Sizes, action and status codes, the per-timer entry layout and the
// command and status groups between controller and datapath.
// ============================================================================
package nitb_pkg;

  // Bank sizing
  localparam int NUM_TIMERS = 64;
  localparam int NEST_BITS  = 8;
  localparam int ADDR_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 6;
  localparam int TIME_W  = 64;
  localparam int CFG_W   = 7;
  localparam int ST_W    = 2;
  localparam int DEPTH_W = 8;
  localparam int TOP_BIT = TIME_W - 1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [ST_W-1:0] ST_IDLE     = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  localparam logic [NEST_BITS-1:0] DEPTH_MAX = '1;

  // One timer's stored state
  typedef struct packed {
    logic [TIME_W-1:0]    stamp;
    logic [TIME_W-1:0]    acc;
    logic [TIME_W-1:0]    count;
    logic [NEST_BITS-1:0] level;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic commit;
  } nitb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } nitb_stat_t;

  localparam int EXT_W = (NEST_BITS > DEPTH_W) ? NEST_BITS : DEPTH_W;

  // Report the low bits of a nesting level at the output width
  function automatic logic [DEPTH_W-1:0] depth_report(input logic [NEST_BITS-1:0] lvl);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(lvl);
    return ext[DEPTH_W-1:0];
  endfunction

endpackage

// ----- rtl/nitb_if.sv -----
// ============================================================================
// nitb_if: handshake channels of the interval timer bank
// Input item, result item and configuration write channels, each with
// valid, ready and payload.
// ============================================================================
interface nitb_in_if;
  logic                           valid;
  logic                           ready;
  logic [nitb_pkg::ACT_W-1:0]     action;
  logic [nitb_pkg::IDX_W-1:0]     timer_index;
  logic [nitb_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, action, timer_index, now_time, input ready);
  modport sink   (input valid, action, timer_index, now_time, output ready);
endinterface

interface nitb_out_if;
  logic                           valid;
  logic                           ready;
  logic [nitb_pkg::ST_W-1:0]      status;
  logic [nitb_pkg::TIME_W-1:0]    total_time;
  logic [nitb_pkg::TIME_W-1:0]    interval_count;
  logic [nitb_pkg::DEPTH_W-1:0]   nest_depth;
  logic                           backwards_time;

  modport source (output valid, status, total_time, interval_count, nest_depth,
                  backwards_time, input ready);
  modport sink   (input valid, status, total_time, interval_count, nest_depth,
                  backwards_time, output ready);
endinterface

interface nitb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nitb_pkg::CFG_W-1:0]     timers_in_use;

  modport source (output valid, timers_in_use, input ready);
  modport sink   (input valid, timers_in_use, output ready);
endinterface

// ----- rtl/nitb_ctrl.sv -----
// ============================================================================
// nitb_ctrl: sequencing controller of the interval timer bank
// Steps each accepted item through lookup, update and commit, and holds
// the commit while the result register is still occupied.
// ============================================================================
module nitb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nitb_pkg::nitb_stat_t stat_i,
  output nitb_pkg::nitb_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_WRITE
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_q;
    cmd_o.calc    = (state_q == S_CALC);
    cmd_o.commit  = (state_q == S_WRITE) && stat_i.out_free;
  end

  assign in_ready_o = in_ready_q;

  // Advance state and hold the registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_CALC;
            in_ready_q <= 1'b0;
          end
        end
        S_CALC: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (stat_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> (state_q == S_IDLE))
    else $error("input ready outside idle");
  a_capture_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (cmd_o.calc && !in_ready_q))
    else $error("accepted item not processed next cycle");
  a_write_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && !stat_i.out_free) |=> (state_q == S_WRITE))
    else $error("write-back left before the result slot was free");
`endif

endmodule

// ----- rtl/nitb_datapath.sv -----
// ============================================================================
// nitb_datapath: timer store and arithmetic of the interval timer bank
// Holds the timer memory with per-entry valid bits, the item registers,
// the nesting and delta update, the total update and the result register.
// ============================================================================
module nitb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nitb_pkg::nitb_cmd_t            cmd_i,
  output nitb_pkg::nitb_stat_t           stat_o,
  input  logic [nitb_pkg::ACT_W-1:0]     action_i,
  input  logic [nitb_pkg::IDX_W-1:0]     timer_index_i,
  input  logic [nitb_pkg::TIME_W-1:0]    now_time_i,
  input  logic                           cfg_valid_i,
  input  logic [nitb_pkg::CFG_W-1:0]     cfg_timers_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nitb_pkg::ST_W-1:0]      status_o,
  output logic [nitb_pkg::TIME_W-1:0]    total_time_o,
  output logic [nitb_pkg::TIME_W-1:0]    interval_count_o,
  output logic [nitb_pkg::DEPTH_W-1:0]   nest_depth_o,
  output logic                           backwards_time_o
);

  localparam int CMP_W = (nitb_pkg::IDX_W + 1 > nitb_pkg::CFG_W)
                         ? nitb_pkg::IDX_W + 1 : nitb_pkg::CFG_W;
  localparam int NT_W  = (CMP_W > 13) ? CMP_W : 13;

  // Configuration
  logic [nitb_pkg::CFG_W-1:0]    timers_q;

  // Timer store
  nitb_pkg::entry_t              mem [nitb_pkg::NUM_TIMERS];
  logic [nitb_pkg::NUM_TIMERS-1:0] valid_q;
  nitb_pkg::entry_t              rdata_q;
  logic                          rvalid_q;

  // Item registers
  logic [nitb_pkg::ACT_W-1:0]    act_q;
  logic [nitb_pkg::TIME_W-1:0]   now_q;
  logic [nitb_pkg::ADDR_W-1:0]   addr_q;
  logic                          range_q;
  logic [nitb_pkg::ADDR_W-1:0]   in_addr;
  logic                          range_d;

  // Update stage
  nitb_pkg::entry_t              row;
  nitb_pkg::entry_t              upd_d, upd_q;
  logic [nitb_pkg::ST_W-1:0]     calc_st_d, calc_st_q;
  logic                          complete_d, complete_q;
  logic [nitb_pkg::TIME_W-1:0]   delta_d, delta_q;

  // Commit stage
  nitb_pkg::entry_t              fin;
  logic                          back;

  // Result register
  logic                          out_valid_q;
  logic [nitb_pkg::ST_W-1:0]     status_q;
  logic [nitb_pkg::TIME_W-1:0]   total_q;
  logic [nitb_pkg::TIME_W-1:0]   count_q;
  logic [nitb_pkg::DEPTH_W-1:0]  depth_q;
  logic                          back_q;

  // Hold the timer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers_q <= '0;
    end else if (cfg_valid_i) begin
      timers_q <= cfg_timers_i;
    end
  end

  // Check the index against the open count and the bank size
  always_comb begin
    in_addr = nitb_pkg::ADDR_W'(timer_index_i);
    range_d = (timers_q == '0)
           || (CMP_W'(timer_index_i) >= CMP_W'(timers_q))
           || (NT_W'(timer_index_i) >= NT_W'(nitb_pkg::NUM_TIMERS));
  end

  // Capture the item on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      now_q   <= now_time_i;
      addr_q  <= in_addr;
      range_q <= range_d;
    end
  end

  // Read the addressed entry on transfer, write back on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdata_q <= mem[in_addr];
    end
    if (cmd_i.commit && !range_q) begin
      mem[addr_q] <= fin;
    end
  end

  // Mark entries written since reset; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        rvalid_q <= valid_q[in_addr];
      end
      if (cmd_i.commit && !range_q) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // Update nesting, start stamp and elapsed time
  always_comb begin
    row        = rvalid_q ? rdata_q : '0;
    upd_d      = row;
    calc_st_d  = nitb_pkg::ST_OK;
    complete_d = 1'b0;
    case (act_q)
      nitb_pkg::ACT_START: begin
        if (row.level == nitb_pkg::DEPTH_MAX) begin
          calc_st_d = nitb_pkg::ST_OVERFLOW;
        end else begin
          if (row.level == '0) begin
            upd_d.stamp = now_q;
          end
          upd_d.level = row.level + nitb_pkg::NEST_BITS'(1);
        end
      end
      nitb_pkg::ACT_STOP: begin
        if (row.level == '0) begin
          calc_st_d = nitb_pkg::ST_IDLE;
        end else begin
          upd_d.level = row.level - nitb_pkg::NEST_BITS'(1);
          complete_d  = (upd_d.level == '0);
        end
      end
      default: begin
      end
    endcase
    delta_d = now_q - row.stamp;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      upd_q      <= upd_d;
      calc_st_q  <= calc_st_d;
      complete_q <= complete_d;
      delta_q    <= delta_d;
    end
  end

  // Count the interval and add the delta unless time went backwards
  always_comb begin
    fin  = upd_q;
    back = complete_q && delta_q[nitb_pkg::TOP_BIT];
    if (complete_q) begin
      fin.count = upd_q.count + nitb_pkg::TIME_W'(1);
      if (!delta_q[nitb_pkg::TOP_BIT]) begin
        fin.acc = upd_q.acc + delta_q;
      end
    end
  end

  // Load the result register on commit, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (range_q) begin
        status_q <= nitb_pkg::ST_RANGE;
        total_q  <= '0;
        count_q  <= '0;
        depth_q  <= '0;
        back_q   <= 1'b0;
      end else begin
        status_q <= calc_st_q;
        total_q  <= fin.acc;
        count_q  <= fin.count;
        depth_q  <= nitb_pkg::depth_report(fin.level);
        back_q   <= back;
      end
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign total_time_o     = total_q;
  assign interval_count_o = count_q;
  assign nest_depth_o     = depth_q;
  assign backwards_time_o = back_q;

`ifndef SYNTH
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == nitb_pkg::ST_RANGE)
      |-> (total_q == '0 && count_q == '0 && depth_q == '0 && !back_q))
    else $error("out-of-range result carries timer data");
  a_back_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && back_q) |-> (status_q == nitb_pkg::ST_OK))
    else $error("backwards flag on a failed item");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(status_q) && $stable(total_q)))
    else $error("stalled result overwritten");
`endif

endmodule

// ----- rtl/nested_interval_timer_bank_top.sv -----
// ============================================================================
// nested_interval_timer_bank_top: bank of nested profiling interval timers
// Start, stop and read timers at given timestamps; reports totals per item.
// ============================================================================
// Usage:
//   in_i   carries one item per transfer: action (start, stop, read),
//          timer_index and now_time. Each item gives exactly one result.
//   out_o  carries the result: status, total_time, interval_count,
//          nest_depth and backwards_time of the addressed timer.
//   cfg_i  writes timers_in_use; it is always ready. Write it only while
//          no item is in flight. Zero closes the log.
// Sequencing:
//   At the transfer edge the timer entry is read from the single-port
//   store; the update step then registers the new nesting and the delta;
//   the commit adds the totals, writes the entry back and loads the
//   output register, waiting while that register still holds a result.
//   Items enter one at a time: a new item is taken only after the last
//   one has committed.
// Reset:
//   All timers read as zero and timers_in_use is zero; per-entry valid
//   bits stand in for the cleared store, so no clearing pass is needed.
// Stall:
//   The result register holds while out_o.ready is low; the next item is
//   taken and processed up to the write-back, which waits for the slot.
// ============================================================================
module nested_interval_timer_bank_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  nitb_in_if.sink       in_i,
  nitb_out_if.source    out_o,
  nitb_cfg_if.sink      cfg_i
);

  nitb_pkg::nitb_cmd_t  cmd;
  nitb_pkg::nitb_stat_t stat;

  assign cfg_i.ready = 1'b1;

  // Sequence each item
  nitb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Store and update the timers
  nitb_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (in_i.action),
    .timer_index_i    (in_i.timer_index),
    .now_time_i       (in_i.now_time),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_timers_i     (cfg_i.timers_in_use),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o         (out_o.status),
    .total_time_o     (out_o.total_time),
    .interval_count_o (out_o.interval_count),
    .nest_depth_o     (out_o.nest_depth),
    .backwards_time_o (out_o.backwards_time)
  );

endmodule

// ----- tb/nested_interval_timer_bank_top_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// nested_interval_timer_bank_top_test: self-checking bench for the timer bank
// Drives start, stop and read items through the valid/ready channels, keeps a
// cycle-free model of every timer's stamp, totals and nesting, and compares
// each result transfer field by field against the oldest predicted result.
// ============================================================================
module nested_interval_timer_bank_top_test;

  // Action code with no name in the package; the block treats it as a read
  localparam logic [nitb_pkg::ACT_W-1:0] ACT_UNDEF = 2'd3;

  typedef struct packed {
    logic [nitb_pkg::ST_W-1:0]    status;
    logic [nitb_pkg::TIME_W-1:0]  total_time;
    logic [nitb_pkg::TIME_W-1:0]  interval_count;
    logic [nitb_pkg::DEPTH_W-1:0] nest_depth;
    logic                         backwards_time;
  } timer_report_t;

  // Per-timer bookkeeping and the queue of results still owed by the block
  class interval_ledger;
    logic [nitb_pkg::CFG_W-1:0]     active_count;
    logic [nitb_pkg::TIME_W-1:0]    stamp     [nitb_pkg::NUM_TIMERS];
    logic [nitb_pkg::TIME_W-1:0]    elapsed   [nitb_pkg::NUM_TIMERS];
    logic [nitb_pkg::TIME_W-1:0]    laps      [nitb_pkg::NUM_TIMERS];
    logic [nitb_pkg::NEST_BITS-1:0] depth     [nitb_pkg::NUM_TIMERS];
    timer_report_t                  owed_reports[$];
    int unsigned                    errors;
    int unsigned                    checked;
    int unsigned                    backwards_seen;
    int unsigned                    overflow_seen;
    int unsigned                    rejected_seen;
    int unsigned                    idle_stop_seen;

    function new();
      active_count = '0;
      foreach (stamp[i]) begin
        stamp[i]   = '0;
        elapsed[i] = '0;
        laps[i]    = '0;
        depth[i]   = '0;
      end
      errors = 0;
      checked = 0;
      backwards_seen = 0;
      overflow_seen = 0;
      rejected_seen = 0;
      idle_stop_seen = 0;
    endfunction

    function void set_count(input logic [nitb_pkg::CFG_W-1:0] n);
      active_count = n;
    endfunction

    // Apply one accepted item to the timers and queue the result it owes
    function void log_item(input logic [nitb_pkg::ACT_W-1:0] act,
                           input logic [nitb_pkg::IDX_W-1:0] idx,
                           input logic [nitb_pkg::TIME_W-1:0] now);
      timer_report_t               r;
      logic [nitb_pkg::TIME_W-1:0] delta;
      r = '0;
      if (active_count == 0 || idx >= active_count) begin
        r.status = nitb_pkg::ST_RANGE;
        rejected_seen++;
      end else begin
        r.status = nitb_pkg::ST_OK;
        case (act)
          nitb_pkg::ACT_START: begin
            if (depth[idx] == nitb_pkg::DEPTH_MAX) begin
              r.status = nitb_pkg::ST_OVERFLOW;
              overflow_seen++;
            end else begin
              if (depth[idx] == 0) stamp[idx] = now;
              depth[idx] = depth[idx] + 1'b1;
            end
          end
          nitb_pkg::ACT_STOP: begin
            if (depth[idx] == 0) begin
              r.status = nitb_pkg::ST_IDLE;
              idle_stop_seen++;
            end else begin
              depth[idx] = depth[idx] - 1'b1;
              // Close the outermost interval; drop a delta that ran backwards
              if (depth[idx] == 0) begin
                delta = now - stamp[idx];
                laps[idx] = laps[idx] + 1'b1;
                if (!delta[nitb_pkg::TOP_BIT]) begin
                  elapsed[idx] = elapsed[idx] + delta;
                end else begin
                  r.backwards_time = 1'b1;
                  backwards_seen++;
                end
              end
            end
          end
          default: ;
        endcase
        r.total_time     = elapsed[idx];
        r.interval_count = laps[idx];
        r.nest_depth     = nitb_pkg::DEPTH_W'(depth[idx]);
      end
      owed_reports.push_back(r);
    endfunction

    task report(input string what);
      if (errors < 40) $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    // Compare one result transfer with the oldest owed result
    task check_report(input timer_report_t got);
      timer_report_t want;
      if (owed_reports.size() == 0) begin
        report($sformatf("unexpected result %p", got));
      end else begin
        want = owed_reports.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.total_time !== want.total_time)
          report($sformatf("total_time got %h want %h", got.total_time, want.total_time));
        if (got.interval_count !== want.interval_count)
          report($sformatf("interval_count got %h want %h",
                           got.interval_count, want.interval_count));
        if (got.nest_depth !== want.nest_depth)
          report($sformatf("nest_depth got %0d want %0d", got.nest_depth, want.nest_depth));
        if (got.backwards_time !== want.backwards_time)
          report($sformatf("backwards_time got %b want %b",
                           got.backwards_time, want.backwards_time));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic calm;
  logic [nitb_pkg::TIME_W-1:0] wall;
  int unsigned items_sent;
  interval_ledger ledger = new();

  nitb_in_if  in_ch ();
  nitb_out_if out_ch ();
  nitb_cfg_if cfg_ch ();

  nested_interval_timer_bank_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("nested_interval_timer_bank_top_test: done, errors");
    $finish;
  end

  // Result side: stall at random except during the calm stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      ledger.check_report({out_ch.status, out_ch.total_time, out_ch.interval_count,
                           out_ch.nest_depth, out_ch.backwards_time});
  end

  // Mostly forward time, with some backward steps, random stamps and jumps
  function automatic logic [nitb_pkg::TIME_W-1:0] next_timestamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      wall = wall + nitb_pkg::TIME_W'($urandom_range(0, 2000));
      return wall;
    end else if (r < 88) begin
      return wall - nitb_pkg::TIME_W'($urandom_range(1, 500));
    end else if (r < 95) begin
      return {$urandom, $urandom};
    end
    wall = {$urandom, $urandom};
    return wall;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(input logic [nitb_pkg::ACT_W-1:0] act,
                           input logic [nitb_pkg::IDX_W-1:0] idx,
                           input logic [nitb_pkg::TIME_W-1:0] now);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.action      = act;
    in_ch.timer_index = idx;
    in_ch.now_time    = now;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    ledger.log_item(act, idx, now);
    items_sent++;
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (ledger.owed_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_timer_count(input logic [nitb_pkg::CFG_W-1:0] n);
    wait_drained();
    @(negedge clk_i);
    cfg_ch.valid         = 1'b1;
    cfg_ch.timers_in_use = n;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    ledger.set_count(n);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    int unsigned phase_count [7];
    logic [nitb_pkg::CFG_W-1:0] phase_cfg [7];
    int unsigned n;
    int unsigned r;
    logic [nitb_pkg::ACT_W-1:0] act;
    logic [nitb_pkg::IDX_W-1:0] idx;

    phase_cfg   = '{7'd64, 7'd17, 7'd2, 7'd0, 7'd63, 7'd64, 7'd40};
    phase_count = '{220, 220, 220, 30, 220, 220, 220};
    calm = 1'b0;
    wall = '0;
    items_sent = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = nitb_pkg::ACT_START;
    in_ch.timer_index = '0;
    in_ch.now_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.timers_in_use = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Log closed after reset
    send_item(nitb_pkg::ACT_START, 6'd0, 64'd5);

    // Directed: idle stop, nesting, extreme deltas, backwards time, wrap
    load_timer_count(7'd64);
    send_item(nitb_pkg::ACT_READ,  6'd63, 64'd0);
    send_item(nitb_pkg::ACT_STOP,  6'd5,  64'd1);
    send_item(nitb_pkg::ACT_START, 6'd0,  64'd0);
    send_item(nitb_pkg::ACT_START, 6'd0,  64'd100);
    send_item(nitb_pkg::ACT_STOP,  6'd0,  64'd200);
    send_item(nitb_pkg::ACT_STOP,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_item(nitb_pkg::ACT_START, 6'd2,  64'd0);
    send_item(nitb_pkg::ACT_STOP,  6'd2,  64'h7FFF_FFFF_FFFF_FFFF);
    send_item(nitb_pkg::ACT_START, 6'd2,  64'h8000_0000_0000_0000);
    send_item(nitb_pkg::ACT_STOP,  6'd2,  64'hFFFF_FFFF_FFFF_FFFF);
    send_item(nitb_pkg::ACT_START, 6'd2,  64'd5);
    send_item(nitb_pkg::ACT_STOP,  6'd2,  64'd5);
    send_item(nitb_pkg::ACT_START, 6'd2,  64'd10);
    send_item(nitb_pkg::ACT_STOP,  6'd2,  64'd12);
    send_item(nitb_pkg::ACT_START, 6'd3,  64'd1000);
    send_item(nitb_pkg::ACT_STOP,  6'd3,  64'd999);
    send_item(ACT_UNDEF,           6'd2,  64'd77);

    // Narrow the bank, then close it; the store must survive both
    load_timer_count(7'd1);
    send_item(nitb_pkg::ACT_START, 6'd1, 64'd3);
    send_item(nitb_pkg::ACT_READ,  6'd0, 64'd3);
    load_timer_count(7'd0);
    send_item(nitb_pkg::ACT_READ,  6'd0, 64'd3);

    // Drive one timer past the nesting limit and unwind it fully
    load_timer_count(7'd64);
    repeat (258) send_item(nitb_pkg::ACT_START, 6'd7, next_timestamp());
    repeat (256) send_item(nitb_pkg::ACT_STOP, 6'd7, next_timestamp());

    // Random phases over several bank sizes; the first runs with no stalls
    foreach (phase_cfg[p]) begin
      load_timer_count(phase_cfg[p]);
      calm = (p == 0);
      n = 32'(phase_cfg[p]);
      for (int k = 0; k < phase_count[p]; k++) begin
        r = $urandom_range(99);
        if (r < 42) act = nitb_pkg::ACT_START;
        else if (r < 82) act = nitb_pkg::ACT_STOP;
        else if (r < 95) act = nitb_pkg::ACT_READ;
        else act = ACT_UNDEF;
        r = $urandom_range(99);
        if (n == 0 || r < 10)
          idx = nitb_pkg::IDX_W'($urandom_range(0, nitb_pkg::NUM_TIMERS - 1));
        else if (r < 70)
          idx = nitb_pkg::IDX_W'($urandom_range(0, (n < 4) ? n - 1 : 3));
        else
          idx = nitb_pkg::IDX_W'($urandom_range(0, n - 1));
        send_item(act, idx, next_timestamp());
        if ($urandom_range(149) == 0) wait_drained();
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d items, %0d results checked, %0d out of range or closed,",
             items_sent, ledger.checked, ledger.rejected_seen);
    $display("  %0d idle stops, %0d nesting overflows, %0d backwards intervals",
             ledger.idle_stop_seen, ledger.overflow_seen, ledger.backwards_seen);
    if (ledger.errors == 0) begin
      $display("nested_interval_timer_bank_top_test: done, clean");
    end else begin
      $display("nested_interval_timer_bank_top_test: done, errors");
    end
    $finish;
  end

endmodule
